/* hw/rtl/bilinear_warp_sampler_top_defines.svh */
// assertion macros shared by the bilinear warp sampler rtl
`ifndef BILINEAR_WARP_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_WARP_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bws same-cycle check failed");

// next-cycle implication, checked out of reset
`define BWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bws next-cycle check failed");

`endif

/* hw/rtl/bws_pkg.sv */
// package with types, codes and constants of the bilinear warp sampler
`default_nettype none
package bws_pkg;

  // fixed field widths
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 10;
  localparam int PIX_W     = 8;
  localparam int PT_W      = 24;
  localparam int OUT_W     = 16;
  localparam int NBANK     = 4;

  // default geometry
  localparam int DEF_COL_BITS  = 10;
  localparam int DEF_ROW_BITS  = 10;
  localparam int DEF_FRAC_BITS = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] MAX_COL_RST = 10'd639;
  localparam logic [CFG_W-1:0] MAX_ROW_RST = 10'd479;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // neighbor mask bits: bit0 floor/floor, bit1 ceil col, bit2 ceil row, bit3 ceil/ceil
  typedef struct packed {
    logic       col_par;   // column parity of floor x
    logic       row_par;   // row parity of floor y
    logic       wx_zero;   // x fraction is zero
    logic       wy_zero;   // y fraction is zero
    logic [3:0] mask;      // neighbor inside image
    logic       last;      // last point of a set
  } side_t;

endpackage
`default_nettype wire

/* hw/rtl/bws_front.sv */
// first stage: floor, fraction, bounds tests and bank addresses
`default_nettype none
module bws_front #(
  parameter int COL_BITS  = bws_pkg::DEF_COL_BITS,
  parameter int ROW_BITS  = bws_pkg::DEF_ROW_BITS,
  parameter int FRAC_BITS = bws_pkg::DEF_FRAC_BITS
) (
  input  wire                                clk,
  input  wire                                en,
  input  wire  [bws_pkg::CFG_W-1:0]          max_col_i,
  input  wire  [bws_pkg::CFG_W-1:0]          max_row_i,
  input  wire                                req_type_i,
  input  wire  [bws_pkg::IDX_W-1:0]          pixel_col_i,
  input  wire  [bws_pkg::IDX_W-1:0]          pixel_row_i,
  input  wire  [bws_pkg::PIX_W-1:0]          pixel_value_i,
  input  wire  signed [bws_pkg::PT_W-1:0]    point_x_i,
  input  wire  signed [bws_pkg::PT_W-1:0]    point_y_i,
  input  wire                                last_i,
  output logic                               ld_r,
  output logic [1:0]                         wr_bank_r,
  output logic [COL_BITS+ROW_BITS-3:0]       wr_addr_r,
  output logic [bws_pkg::PIX_W-1:0]          wr_data_r,
  output logic [COL_BITS+ROW_BITS-3:0]       rd_addr_r [bws_pkg::NBANK],
  output logic [FRAC_BITS-1:0]               wx_r,
  output logic [FRAC_BITS-1:0]               wy_r,
  output bws_pkg::side_t                     side_r
);
  import bws_pkg::*;

  localparam int IW   = PT_W - FRAC_BITS;
  localparam int BA_W = COL_BITS + ROW_BITS - 2;

  logic signed [IW-1:0]   fx, fy;
  logic signed [IW-1:0]   col_lim, row_lim;
  logic signed [PT_W-1:0] x_lim, y_lim;
  logic                   fxo, fyo, xo, yo;
  logic [COL_BITS-1:0]    c0, c1;
  logic [ROW_BITS-1:0]    r0, r1;
  logic [COL_BITS+IDX_W-1:0] colx;
  logic [ROW_BITS+IDX_W-1:0] rowx;
  logic [COL_BITS-1:0]    cw;
  logic [ROW_BITS-1:0]    rw;
  logic [BA_W-1:0]        rd_addr_nxt [NBANK];
  side_t                  side_nxt;

  // floor parts and bounds tests
  always_comb begin
    fx      = point_x_i[PT_W-1:FRAC_BITS];
    fy      = point_y_i[PT_W-1:FRAC_BITS];
    col_lim = {{(IW-CFG_W){1'b0}}, max_col_i};
    row_lim = {{(IW-CFG_W){1'b0}}, max_row_i};
    x_lim   = {{(PT_W-CFG_W-FRAC_BITS){1'b0}}, max_col_i, {FRAC_BITS{1'b0}}};
    y_lim   = {{(PT_W-CFG_W-FRAC_BITS){1'b0}}, max_row_i, {FRAC_BITS{1'b0}}};
    fxo     = fx[IW-1] | (fx > col_lim);
    fyo     = fy[IW-1] | (fy > row_lim);
    xo      = point_x_i[PT_W-1] | (point_x_i > x_lim);
    yo      = point_y_i[PT_W-1] | (point_y_i > y_lim);
  end

  // neighbor coordinates and one read address per parity bank
  always_comb begin
    logic [COL_BITS-1:0] ck;
    logic [ROW_BITS-1:0] rk;
    c0 = fx[COL_BITS-1:0];
    c1 = c0 + COL_BITS'(1);
    r0 = fy[ROW_BITS-1:0];
    r1 = r0 + ROW_BITS'(1);
    ck = c0;
    rk = r0;
    for (int k = 0; k < NBANK; k++) begin
      ck = (c0[0] == k[0]) ? c0 : c1;
      rk = (r0[0] == k[1]) ? r0 : r1;
      rd_addr_nxt[k] = {rk[ROW_BITS-1:1], ck[COL_BITS-1:1]};
    end
  end

  // load address, wrapped to the memory size
  always_comb begin
    colx = {{COL_BITS{1'b0}}, pixel_col_i};
    rowx = {{ROW_BITS{1'b0}}, pixel_row_i};
    cw   = colx[COL_BITS-1:0];
    rw   = rowx[ROW_BITS-1:0];
  end

  // sideband flags
  always_comb begin
    side_nxt.col_par = c0[0];
    side_nxt.row_par = r0[0];
    side_nxt.wx_zero = ~|point_x_i[FRAC_BITS-1:0];
    side_nxt.wy_zero = ~|point_y_i[FRAC_BITS-1:0];
    side_nxt.mask    = {~(xo | yo), ~(fxo | yo), ~(xo | fyo), ~(fxo | fyo)};
    side_nxt.last    = last_i;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      ld_r      <= (req_type_i == REQ_LOAD);
      wr_bank_r <= {rw[0], cw[0]};
      wr_addr_r <= {rw[ROW_BITS-1:1], cw[COL_BITS-1:1]};
      wr_data_r <= pixel_value_i;
      rd_addr_r <= rd_addr_nxt;
      wx_r      <= point_x_i[FRAC_BITS-1:0];
      wy_r      <= point_y_i[FRAC_BITS-1:0];
      side_r    <= side_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bws_bank.sv */
// one parity bank of the image memory, registered read
`default_nettype none
module bws_bank #(
  parameter int COL_BITS = bws_pkg::DEF_COL_BITS,
  parameter int ROW_BITS = bws_pkg::DEF_ROW_BITS
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire  [COL_BITS+ROW_BITS-3:0]      waddr,
  input  wire  [bws_pkg::PIX_W-1:0]         wdata,
  input  wire                               re,
  input  wire  [COL_BITS+ROW_BITS-3:0]      raddr,
  output logic [bws_pkg::PIX_W-1:0]         rdata_r
);
  import bws_pkg::*;

  localparam int BA_W  = COL_BITS + ROW_BITS - 2;
  localparam int DEPTH = 1 << BA_W;

  logic [PIX_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bws_lerp.sv */
// interpolation stages: row blends, then column blend and truncation
`default_nettype none
module bws_lerp #(
  parameter int FRAC_BITS = bws_pkg::DEF_FRAC_BITS
) (
  input  wire                           clk,
  input  wire                           en3,
  input  wire                           en4,
  input  wire  [bws_pkg::PIX_W-1:0]     data_i [bws_pkg::NBANK],
  input  wire  [FRAC_BITS-1:0]          wx_i,
  input  wire  [FRAC_BITS-1:0]          wy_i,
  input  wire  bws_pkg::side_t          side_i,
  output logic [bws_pkg::OUT_W-1:0]     intensity_r,
  output logic                          all_out_r,
  output logic                          last_r
);
  import bws_pkg::*;

  localparam int TW = FRAC_BITS + PIX_W;
  localparam int VW = 2 * FRAC_BITS + PIX_W;

  logic [FRAC_BITS:0]  one_fx;
  logic [1:0]          i00, i10, i01, i11;
  logic [PIX_W-1:0]    p00, p10, p01, p11;
  logic [FRAC_BITS:0]  wxc, wyc;
  logic [TW:0]         top_sum, bot_sum;
  logic [TW-1:0]       top3_r, bot3_r;
  logic [FRAC_BITS-1:0] wy3_r;
  logic                all_out3_r, last3_r;
  logic [VW:0]         val;

  // pick each neighbor from its bank, zero outside the image
  always_comb begin
    logic ar, bb;
    ar  = side_i.wx_zero ? side_i.col_par : ~side_i.col_par;
    bb  = side_i.wy_zero ? side_i.row_par : ~side_i.row_par;
    i00 = {side_i.row_par, side_i.col_par};
    i10 = {side_i.row_par, ar};
    i01 = {bb, side_i.col_par};
    i11 = {bb, ar};
    p00 = data_i[i00] & {PIX_W{side_i.mask[0]}};
    p10 = data_i[i10] & {PIX_W{side_i.mask[1]}};
    p01 = data_i[i01] & {PIX_W{side_i.mask[2]}};
    p11 = data_i[i11] & {PIX_W{side_i.mask[3]}};
  end

  // horizontal blends of both rows
  always_comb begin
    one_fx  = {1'b1, {FRAC_BITS{1'b0}}};
    wxc     = one_fx - {1'b0, wx_i};
    top_sum = (TW+1)'(wxc * p00) + (TW+1)'({1'b0, wx_i} * p10);
    bot_sum = (TW+1)'(wxc * p01) + (TW+1)'({1'b0, wx_i} * p11);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      top3_r     <= top_sum[TW-1:0];
      bot3_r     <= bot_sum[TW-1:0];
      wy3_r      <= wy_i;
      all_out3_r <= ~|side_i.mask;
      last3_r    <= side_i.last;
    end
  end

  // vertical blend, truncated to q8.8
  always_comb begin
    wyc = one_fx - {1'b0, wy3_r};
    val = (VW+1)'(wyc * top3_r) + (VW+1)'({1'b0, wy3_r} * bot3_r);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      intensity_r <= val[VW-1:VW-OUT_W];
      all_out_r   <= all_out3_r;
      last_r      <= last3_r;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bilinear_warp_sampler_top.sv */
// Bilinear warp sampler top level: handshake, config registers, banks, pipeline.
// A sample word passes stage one, the bank read, the row blends and the output register before out_valid shows it.
// Throughput: one word per cycle while out_stall does not hold the pipe; four parity banks serve all neighbors at once.
// A load word writes its bank as it leaves stage one; a stall can hold it in stage one first.
// Reset clears valid bits and sets max_col 639, max_row 479; image memory is not cleared.
`default_nettype none
`include "bilinear_warp_sampler_top_defines.svh"
module bilinear_warp_sampler_top #(
  parameter int COL_BITS  = bws_pkg::DEF_COL_BITS,
  parameter int ROW_BITS  = bws_pkg::DEF_ROW_BITS,
  parameter int FRAC_BITS = bws_pkg::DEF_FRAC_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // configuration write
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bws_pkg::CFG_W-1:0]        cfg_data,
  // input words
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_req_type,
  input  wire  [bws_pkg::IDX_W-1:0]        in_pixel_col,
  input  wire  [bws_pkg::IDX_W-1:0]        in_pixel_row,
  input  wire  [bws_pkg::PIX_W-1:0]        in_pixel_value,
  input  wire  signed [bws_pkg::PT_W-1:0]  in_point_x,
  input  wire  signed [bws_pkg::PT_W-1:0]  in_point_y,
  input  wire                              in_last_point,
  // result words
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [bws_pkg::OUT_W-1:0]        out_intensity,
  output logic                             out_all_outside,
  output logic                             out_last_out
);
  import bws_pkg::*;

  localparam int BA_W = COL_BITS + ROW_BITS - 2;

  logic [CFG_W-1:0]     max_col_r, max_row_r;
  logic                 v1_r, v2_r, v3_r, out_valid_r;
  logic                 en1, en2, en3, en4;
  logic                 ld1_r;
  logic [1:0]           wr_bank1_r;
  logic [BA_W-1:0]      wr_addr1_r;
  logic [PIX_W-1:0]     wr_data1_r;
  logic [BA_W-1:0]      rd_addr1_r [NBANK];
  logic [FRAC_BITS-1:0] wx1_r, wy1_r, wx2_r, wy2_r;
  side_t                side1_r, side2_r;
  logic [PIX_W-1:0]     bank_data [NBANK];
  logic                 wr_go;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_col_r <= MAX_COL_RST;
      max_row_r <= MAX_ROW_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_COL) begin
        max_col_r <= cfg_data;
      end
      if (cfg_index == REG_MAX_ROW) begin
        max_row_r <= cfg_data;
      end
    end
  end

  // per-stage advance: a stage moves when it is empty or its successor moves
  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // valid bits travel with the data; loads drop out after their write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r && !ld1_r;
      if (en3) v3_r <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  // address and bounds stage
  bws_front #(
    .COL_BITS  (COL_BITS),
    .ROW_BITS  (ROW_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .en            (en1),
    .max_col_i     (max_col_r),
    .max_row_i     (max_row_r),
    .req_type_i    (in_req_type),
    .pixel_col_i   (in_pixel_col),
    .pixel_row_i   (in_pixel_row),
    .pixel_value_i (in_pixel_value),
    .point_x_i     (in_point_x),
    .point_y_i     (in_point_y),
    .last_i        (in_last_point),
    .ld_r          (ld1_r),
    .wr_bank_r     (wr_bank1_r),
    .wr_addr_r     (wr_addr1_r),
    .wr_data_r     (wr_data1_r),
    .rd_addr_r     (rd_addr1_r),
    .wx_r          (wx1_r),
    .wy_r          (wy1_r),
    .side_r        (side1_r)
  );

  // memory stage: the load writes as it leaves stage one
  assign wr_go = v1_r && ld1_r && en2;

  for (genvar k = 0; k < NBANK; k++) begin : g_bank
    bws_bank #(
      .COL_BITS (COL_BITS),
      .ROW_BITS (ROW_BITS)
    ) u_bank (
      .clk     (clk),
      .we      (wr_go && (wr_bank1_r == 2'(k))),
      .waddr   (wr_addr1_r),
      .wdata   (wr_data1_r),
      .re      (en2),
      .raddr   (rd_addr1_r[k]),
      .rdata_r (bank_data[k])
    );
  end

  // sideband alongside the read data
  always_ff @(posedge clk) begin
    if (en2) begin
      wx2_r   <= wx1_r;
      wy2_r   <= wy1_r;
      side2_r <= side1_r;
    end
  end

  // interpolation and output register
  bws_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk         (clk),
    .en3         (en3),
    .en4         (en4),
    .data_i      (bank_data),
    .wx_i        (wx2_r),
    .wy_i        (wy2_r),
    .side_i      (side2_r),
    .intensity_r (out_intensity),
    .all_out_r   (out_all_outside),
    .last_r      (out_last_out)
  );

  assign out_valid = out_valid_r;

  // checks
  `BWS_ASSERT_IMP(a_all_out_zero, out_valid && out_all_outside, out_intensity == '0)
  `BWS_ASSERT_NXT(a_load_no_result, en2 && v1_r && ld1_r, !v2_r)
  `BWS_ASSERT_IMP(a_empty_out_accepts, !out_valid_r, !in_stall)

endmodule
`default_nettype wire

/* bench/tb.sv */
// self-checking testbench for the bilinear warp sampler: directed, random and back-pressure runs
module tb;
  import bws_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 200;
  localparam int FRAC          = DEF_FRAC_BITS;
  localparam int ONE           = 1 << FRAC;
  localparam int ADDR_W        = DEF_COL_BITS + DEF_ROW_BITS;

  // register indexes past the end of the list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] intensity;
    logic             all_outside;
    logic             last;
  } sample_res_t;

  // dut ports
  logic                    clk;
  logic                    rst_n           = 1'b0;
  logic                    cfg_valid       = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index       = '0;
  logic [CFG_W-1:0]        cfg_data        = '0;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic                    in_req_type     = REQ_LOAD;
  logic [IDX_W-1:0]        in_pixel_col    = '0;
  logic [IDX_W-1:0]        in_pixel_row    = '0;
  logic [PIX_W-1:0]        in_pixel_value  = '0;
  logic signed [PT_W-1:0]  in_point_x      = '0;
  logic signed [PT_W-1:0]  in_point_y      = '0;
  logic                    in_last_point   = 1'b0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [OUT_W-1:0]        out_intensity;
  logic                    out_all_outside;
  logic                    out_last_out;

  // predictor state
  logic [7:0]         image_px [int unsigned];
  logic [CFG_W-1:0]   bound_col = MAX_COL_RST;
  logic [CFG_W-1:0]   bound_row = MAX_ROW_RST;
  sample_res_t        pending_samples [$];

  // traffic shaping and bookkeeping
  int in_idle_pct  = 36;
  int out_idle_pct = 75;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int err_count    = 0;
  int quiet_cycles = 0;

  bilinear_warp_sampler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_pixel_col    (in_pixel_col),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_value  (in_pixel_value),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_intensity   (out_intensity),
    .out_all_outside (out_all_outside),
    .out_last_out    (out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // neighbor order: floor/floor, ceil col, ceil row, ceil/ceil
  // floors are tested on their own, ceilings through the exact coordinate
  function automatic void locate_neighbours(input logic signed [PT_W-1:0] px, py,
                                            output logic [3:0] in_img,
                                            output logic [3:0][ADDR_W-1:0] addr,
                                            output longint wx, wy);
    longint x, y, fx, fy, cx, cy, lim_c, lim_r;
    logic fxo, fyo, xo, yo;
    x = px;
    y = py;
    wx = px[FRAC-1:0];
    wy = py[FRAC-1:0];
    fx = x >>> FRAC;
    fy = y >>> FRAC;
    cx = (wx != 0) ? fx + 1 : fx;
    cy = (wy != 0) ? fy + 1 : fy;
    lim_c = bound_col;
    lim_r = bound_row;
    fxo = (fx < 0) || (fx > lim_c);
    fyo = (fy < 0) || (fy > lim_r);
    xo  = (x < 0) || (x > lim_c * ONE);
    yo  = (y < 0) || (y > lim_r * ONE);
    in_img = {~(xo | yo), ~(fxo | yo), ~(xo | fyo), ~(fxo | fyo)};
    addr[0] = {fy[DEF_ROW_BITS-1:0], fx[DEF_COL_BITS-1:0]};
    addr[1] = {fy[DEF_ROW_BITS-1:0], cx[DEF_COL_BITS-1:0]};
    addr[2] = {cy[DEF_ROW_BITS-1:0], fx[DEF_COL_BITS-1:0]};
    addr[3] = {cy[DEF_ROW_BITS-1:0], cx[DEF_COL_BITS-1:0]};
  endfunction

  // bilinear blend of the four neighbors, truncated to q8.8
  function automatic sample_res_t interpolate(input logic signed [PT_W-1:0] px, py,
                                              input logic last);
    logic [3:0] in_img;
    logic [3:0][ADDR_W-1:0] addr;
    longint wx, wy, top, bot, acc;
    longint p [NBANK];
    sample_res_t r;
    locate_neighbours(px, py, in_img, addr, wx, wy);
    for (int i = 0; i < NBANK; i++) begin
      p[i] = in_img[i] ? longint'(image_px[addr[i]]) : 64'sd0;
    end
    r.last = last;
    r.all_outside = (in_img == 4'b0000);
    if (r.all_outside) begin
      r.intensity = '0;
    end else begin
      top = (ONE - wx) * p[0] + wx * p[1];
      bot = (ONE - wx) * p[2] + wx * p[3];
      acc = (ONE - wy) * top + wy * bot;
      r.intensity = OUT_W'(acc >> (2 * FRAC - PIX_W));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // one input word, held until accepted; the model is updated at acceptance
  task automatic send_word(input logic req, input logic [IDX_W-1:0] col, row,
                           input logic [PIX_W-1:0] value,
                           input logic signed [PT_W-1:0] px, py, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_pixel_col   <= col;
    in_pixel_row   <= row;
    in_pixel_value <= value;
    in_point_x     <= px;
    in_point_y     <= py;
    in_last_point  <= last;
    do @(posedge clk); while (in_stall);
    if (req == REQ_LOAD) begin
      image_px[{row, col}] = value;
    end else begin
      pending_samples.push_back(interpolate(px, py, last));
    end
  endtask

  task automatic load_pixel(input logic [IDX_W-1:0] col, row, input logic [PIX_W-1:0] value);
    send_word(REQ_LOAD, col, row, value, PT_W'($urandom), PT_W'($urandom), 1'($urandom));
  endtask

  // loads any neighbor that will be read but was never written, then samples
  task automatic sample_point(input int x, input int y, input logic last);
    logic signed [PT_W-1:0] px, py;
    logic [3:0] in_img;
    logic [3:0][ADDR_W-1:0] addr;
    longint wx, wy;
    px = x[PT_W-1:0];
    py = y[PT_W-1:0];
    locate_neighbours(px, py, in_img, addr, wx, wy);
    for (int i = 0; i < NBANK; i++) begin
      if (in_img[i] && !image_px.exists(addr[i])) begin
        load_pixel(addr[i][IDX_W-1:0], addr[i][ADDR_W-1:IDX_W], PIX_W'($urandom));
      end
    end
    send_word(REQ_SAMPLE, IDX_W'($urandom), IDX_W'($urandom), PIX_W'($urandom),
              px, py, last);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_COL: bound_col = data;
      REG_MAX_ROW: bound_row = data;
      default: ;
    endcase
  endtask

  task automatic apply_bounds(input logic [CFG_W-1:0] col_lim, row_lim);
    write_register(REG_MAX_COL, col_lim);
    write_register(REG_MAX_ROW, row_lim);
    cfg_valid <= 1'b0;
  endtask

  // stop offering words until every pending sample came back, then let the pipe settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // coordinate around an image axis of largest index lim
  function automatic int gen_coord(input int lim);
    case ($urandom_range(9))
      0: return int'($urandom_range(lim)) * ONE;
      1: return lim * ONE + int'($urandom_range(1));
      2: return lim * ONE + ONE - 1;
      3: return -int'($urandom_range(2 * ONE, 1));
      4: return lim * ONE + int'($urandom_range(3 * ONE, 2));
      default: return int'($urandom_range(lim * ONE + ONE - 1));
    endcase
  endfunction

  // bounds as they come out of reset
  task automatic test_reset_bounds();
    sample_point(639 * ONE, 479 * ONE, 1'b1);
    sample_point(639 * ONE + 1, 479 * ONE, 1'b0);
    sample_point(638 * ONE + 17, 478 * ONE + 250, 1'b1);
    wait_for_results();
  endtask

  // edges of the point fields, exact and floor bounds, dropped register writes
  task automatic test_directed_points();
    apply_bounds(10'd7, 10'd5);
    load_pixel(10'h3FF, 10'h3FF, 8'hFF);
    load_pixel(10'h000, 10'h000, 8'h00);
    sample_point(0, 0, 1'b1);
    sample_point(7 * ONE, 5 * ONE, 1'b0);
    // floor inside, exact coordinate just past the edge
    sample_point(7 * ONE + 1, 5 * ONE + 1, 1'b1);
    sample_point(8 * ONE - 1, 6 * ONE - 1, 1'b0);
    sample_point(-1, -1, 1'b0);
    sample_point(-ONE, ONE / 2, 1'b1);
    sample_point(ONE / 2, -1, 1'b0);
    sample_point(3 * ONE + ONE / 2, 2 * ONE + 77, 1'b1);
    sample_point(ONE - 1, ONE - 1, 1'b0);
    sample_point(6 * ONE + 200, 0, 1'b1);
    sample_point(8388607, 8388607, 1'b0);
    sample_point(-8388608, -8388608, 1'b1);
    sample_point(-8388608, 8388607, 1'b0);
    wait_for_results();
    write_register(REG_SPARE_LO, 10'h3FF);
    write_register(REG_SPARE_HI, 10'h000);
    cfg_valid <= 1'b0;
    sample_point(7 * ONE + 1, 5 * ONE, 1'b0);
    sample_point(8 * ONE, 2 * ONE, 1'b1);
    wait_for_results();
  endtask

  // largest and smallest image sizes
  task automatic test_bound_extremes();
    apply_bounds(10'd1023, 10'd1023);
    sample_point(1023 * ONE, 1023 * ONE, 1'b1);
    sample_point(1022 * ONE + 255, 1022 * ONE + 255, 1'b0);
    sample_point(1023 * ONE + 1, 1023 * ONE + 128, 1'b1);
    sample_point(1024 * ONE, 0, 1'b0);
    wait_for_results();
    apply_bounds(10'd0, 10'd0);
    sample_point(0, 0, 1'b1);
    sample_point(1, 1, 1'b0);
    sample_point(0, ONE, 1'b1);
    sample_point(ONE - 1, 0, 1'b0);
    sample_point(-1, 0, 1'b1);
    wait_for_results();
  endtask

  // mostly well-formed points with some raw loads, raw points and full pauses
  task automatic test_random_traffic(input int sender_idle, receiver_idle,
                                     input logic [CFG_W-1:0] col_lim, row_lim,
                                     input int count);
    int pick;
    in_idle_pct  = sender_idle;
    out_idle_pct = receiver_idle;
    apply_bounds(col_lim, row_lim);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        load_pixel(IDX_W'($urandom), IDX_W'($urandom), PIX_W'($urandom));
      end else if (pick < 8) begin
        load_pixel(IDX_W'($urandom_range(col_lim)), IDX_W'($urandom_range(row_lim)),
                   PIX_W'($urandom));
      end else if (pick < 14) begin
        sample_point(int'($urandom), int'($urandom), 1'($urandom_range(1)));
      end else if (pick < 15) begin
        wait_for_results();
      end else begin
        sample_point(gen_coord(col_lim), gen_coord(row_lim), $urandom_range(7) == 0);
      end
    end
    wait_for_results();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apply_bounds(10'd31, 10'd31);
    hold_reqs <= hold_reqs + 1;
    repeat (80) sample_point(gen_coord(31), gen_coord(31), 1'($urandom_range(1)));
    wait_for_results();
  endtask

  // result side stall, random or a counted hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    sample_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result word", out_intensity, 0);
      end else begin
        want = pending_samples.pop_front();
        if (out_intensity !== want.intensity)
          report_mismatch("intensity", out_intensity, want.intensity);
        if (out_all_outside !== want.all_outside)
          report_mismatch("all_outside", out_all_outside, want.all_outside);
        if (out_last_out !== want.last)
          report_mismatch("last_out", out_last_out, want.last);
      end
    end
  end

  // end the run when no handshake happens for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_bounds();
    test_directed_points();
    test_bound_extremes();
    test_random_traffic(36, 75, 10'd15, 10'd9, 600);
    test_random_traffic(75, 36, 10'd1023, 10'd1023, 150);
    test_random_traffic(0, 0, 10'd0, 10'd31, 500);
    test_backpressure();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
